// ===== design/rr_pkg.sv =====
// ============================================================================
// rr_pkg
// Shared constants and types of the reprojection residual pipeline.
// ============================================================================
package rr_pkg;

    // Restoring divider shape. Quotients are 31 bits; the dividend is wide
    // enough for the rotation case and the divisor for the depth case.
    localparam int QW      = 31;
    localparam int DVD_W   = 63;
    localparam int DSR_W   = 34;
    localparam int DIV_LAT = QW;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FOCAL = 2'd0,
        CFG_PX    = 2'd1,
        CFG_PY    = 2'd2,
        CFG_K     = 2'd3
    } t_cfg_idx;

    // Item data carried beside the rotation arithmetic.
    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic signed [31:0] pt_x;
        logic signed [31:0] pt_y;
        logic signed [31:0] pt_z;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
    } t_early;

    typedef struct packed {
        t_early     e;
        logic [8:0] neg;
        logic [8:0] ovf;
        logic       bad;
    } t_rot_side;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic               bad;
    } t_obs;

    typedef struct packed {
        t_obs ob;
        logic negx;
        logic negy;
        logic ovfx;
        logic ovfy;
    } t_dep_side;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] xp;
        logic signed [31:0] yp;
        logic               bad;
        logic               sat;
    } t_late;

endpackage

// ===== design/rr_div.sv =====
// ============================================================================
// rr_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees dividend < divisor * 2^QW for the result to be exact.
// ============================================================================
module rr_div (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [rr_pkg::DVD_W-1:0] i_dvd,
    input  logic [rr_pkg::DSR_W-1:0] i_dsr,
    output logic [rr_pkg::QW-1:0]    o_quo
);
    import rr_pkg::*;

    localparam int HI_W = DVD_W - QW;

    logic [DSR_W-1:0] r_rem [QW];
    logic [QW-1:0]    r_low [QW];
    logic [DSR_W-1:0] r_dsr [QW];
    logic [QW-1:0]    r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DSR_W-1:0] s_rem;
        logic [DSR_W-1:0] s_dsr;
        logic [QW-1:0]    s_low;
        logic [QW-1:0]    s_quo;
        logic [DSR_W:0]   s_try;
        logic [DSR_W:0]   s_diff;
        logic             s_ge;
        logic [DSR_W-1:0] n_rem;
        logic [QW-1:0]    n_quo;

        if (k == 0) begin : g_first
            assign s_rem = {{(DSR_W-HI_W){1'b0}}, i_dvd[DVD_W-1:QW]};
            assign s_low = i_dvd[QW-1:0];
            assign s_dsr = i_dsr;
            assign s_quo = '0;
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_low = r_low[k-1];
            assign s_dsr = r_dsr[k-1];
            assign s_quo = r_quo[k-1];
        end

        always_comb begin
            s_try  = {s_rem, s_low[QW-1-k]};
            s_diff = s_try - {1'b0, s_dsr};
            s_ge   = (s_try >= {1'b0, s_dsr});
            n_rem  = s_ge ? s_diff[DSR_W-1:0] : s_try[DSR_W-1:0];
            n_quo  = s_quo;
            n_quo[QW-1-k] = s_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_low[k] <= s_low;
                r_dsr[k] <= s_dsr;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// ===== design/reprojection_residual_top.sv =====
// ============================================================================
// reprojection_residual_top
// Reprojection residual of one observation with one-term radial distortion.
// ============================================================================
// Usage:
// The input channel (i_valid / o_stall) carries one observation: camera
// quaternion, translation, world point and observed pixel. The output
// channel (o_valid / i_stall) returns the residual pair with the
// bad_divide and saturated flags, one result per observation, in order.
// Intrinsics are written through i_cfg_we / i_cfg_idx / i_cfg_data while
// the pipeline is empty.
// An item passes through 79 register stages, and o_valid rises once it has
// reached the last one. Throughput is one observation per cycle while the
// receiver does not stall; it is set by the 79-stage pipeline, with two
// 31-stage bit-per-stage divider banks (rotation normalize and depth divide).
// The whole pipeline moves under one enable. When the receiver stalls a
// valid result, every stage holds and o_stall rises in the same cycle, so
// nothing is dropped or repeated.
// Reset clears all valid bits and loads the intrinsics to focal 1.0,
// zero principal point and zero distortion.
// ============================================================================
module reprojection_residual_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_quat_w,
    input  logic signed [31:0] i_quat_x,
    input  logic signed [31:0] i_quat_y,
    input  logic signed [31:0] i_quat_z,
    input  logic signed [31:0] i_trans_x,
    input  logic signed [31:0] i_trans_y,
    input  logic signed [31:0] i_trans_z,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_obs_x,
    input  logic signed [31:0] i_obs_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_residual_x,
    output logic signed [31:0] o_residual_y,
    output logic               o_bad_divide,
    output logic               o_saturated,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import rr_pkg::*;

    localparam int LAT = 4 + DIV_LAT + 4 + DIV_LAT + 9;

    function automatic logic signed [31:0] f_clamp(input logic signed [41:0] v);
        if (v > 42'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -42'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic f_over(input logic signed [41:0] v);
        return (v > 42'sd2147483647) || (v < -42'sd2147483648);
    endfunction

    // Configuration
    logic [30:0]        r_focal;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= 31'd65536;
            r_px    <= '0;
            r_py    <= '0;
            r_k     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FOCAL: r_focal <= i_cfg_data[30:0];
                CFG_PX:    r_px    <= i_cfg_data;
                CFG_PY:    r_py    <= i_cfg_data;
                CFG_K:     r_k     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Stage registers
    logic signed [31:0] r1_qw, r1_qx, r1_qy, r1_qz;
    t_early             r1_e;

    logic signed [31:0] r2_ww, r2_xx, r2_yy, r2_zz, r2_xy;
    logic signed [31:0] r2_xz, r2_yz, r2_wx, r2_wy, r2_wz;
    t_early             r2_e;

    logic [32:0]        r3_n;
    logic signed [33:0] r3_a [9];
    t_early             r3_e;

    logic [32:0]        r4_abs [9];
    logic [32:0]        r4_n;
    t_rot_side          r4_side;

    t_rot_side          r_d1 [DIV_LAT];
    logic [QW-1:0]      s_q1 [9];

    logic signed [31:0] r5_r [9];
    t_early             r5_e;
    logic               r5_bad;

    logic signed [63:0] r6_m [9];
    t_early             r6_e;
    logic               r6_bad;

    logic signed [34:0] r7_c [3];
    t_obs               r7_ob;

    logic [33:0]        r8_absx, r8_absy, r8_absz;
    t_dep_side          r8_side;

    t_dep_side          r_d2 [DIV_LAT];
    logic [QW-1:0]      s_qx, s_qy;

    t_late              r9_l;
    logic [61:0]        r10_xx, r10_yy;
    t_late              r10_l;
    logic [30:0]        r11_r2;
    t_late              r11_l;
    logic signed [63:0] r12_kr;
    t_late              r12_l;
    logic signed [31:0] r13_dist;
    t_late              r13_l;
    logic signed [63:0] r14_fdp;
    t_late              r14_l;
    logic signed [31:0] r15_fd;
    t_late              r15_l;
    logic signed [63:0] r16_ux, r16_uy;
    t_late              r16_l;

    logic signed [31:0] r_res_x, r_res_y;
    logic               r_bad, r_sat;

    // Combinational stage logic
    logic signed [63:0] s_ww, s_xx, s_yy, s_zz, s_xy, s_xz, s_yz, s_wx, s_wy, s_wz;
    logic signed [34:0] s_n;
    logic signed [33:0] s_a [9];
    logic signed [33:0] s_mag [9];
    logic [8:0]         s_neg, s_ovf;
    t_rot_side          n_side1;
    logic [30:0]        s_rmag [9];
    logic signed [31:0] s_pt [3];
    logic signed [31:0] s_tr [3];
    logic signed [63:0] s_sum [3];
    logic signed [34:0] s_cmag [3];
    t_dep_side          n_side2;
    logic [30:0]        s_xm, s_ym;
    t_late              n_l9;
    logic signed [63:0] s_xsq, s_ysq;
    logic [62:0]        s_sq;
    logic               s_r2_over;
    logic signed [41:0] s_df, s_fd, s_ux, s_uy;
    t_late              n_l11, n_l13, n_l15;

    always_comb begin
        s_ww = r1_qw * r1_qw;  s_xx = r1_qx * r1_qx;
        s_yy = r1_qy * r1_qy;  s_zz = r1_qz * r1_qz;
        s_xy = r1_qx * r1_qy;  s_xz = r1_qx * r1_qz;
        s_yz = r1_qy * r1_qz;  s_wx = r1_qw * r1_qx;
        s_wy = r1_qw * r1_qy;  s_wz = r1_qw * r1_qz;

        s_n    = r2_ww + r2_xx + r2_yy + r2_zz;
        s_a[0] = r2_ww + r2_xx - r2_yy - r2_zz;
        s_a[1] = (r2_xy - r2_wz) + (r2_xy - r2_wz);
        s_a[2] = (r2_xz + r2_wy) + (r2_xz + r2_wy);
        s_a[3] = (r2_xy + r2_wz) + (r2_xy + r2_wz);
        s_a[4] = r2_ww - r2_xx + r2_yy - r2_zz;
        s_a[5] = (r2_yz - r2_wx) + (r2_yz - r2_wx);
        s_a[6] = (r2_xz - r2_wy) + (r2_xz - r2_wy);
        s_a[7] = (r2_yz + r2_wx) + (r2_yz + r2_wx);
        s_a[8] = r2_ww - r2_xx - r2_yy + r2_zz;

        // A quotient of 2^31 or more shows up as |a| >= 2n.
        for (int j = 0; j < 9; j++) begin
            s_neg[j] = r3_a[j][33];
            s_mag[j] = s_neg[j] ? -r3_a[j] : r3_a[j];
            s_ovf[j] = ({1'b0, s_mag[j][32:0]} >= {r3_n, 1'b0});
        end
        n_side1.e   = r3_e;
        n_side1.neg = s_neg;
        n_side1.ovf = s_ovf;
        n_side1.bad = (r3_n == '0);

        // Rotation entries are clamped to one without flagging.
        for (int j = 0; j < 9; j++) begin
            if (r_d1[DIV_LAT-1].ovf[j] || (s_q1[j] > 31'd1073741824)) begin
                s_rmag[j] = 31'd1073741824;
            end else begin
                s_rmag[j] = s_q1[j];
            end
        end

        s_pt[0] = r5_e.pt_x;  s_pt[1] = r5_e.pt_y;  s_pt[2] = r5_e.pt_z;
        s_tr[0] = r6_e.tx;    s_tr[1] = r6_e.ty;    s_tr[2] = r6_e.tz;
        for (int i = 0; i < 3; i++) begin
            s_sum[i] = r6_m[3*i] + r6_m[3*i+1] + r6_m[3*i+2];
        end

        for (int i = 0; i < 3; i++) begin
            s_cmag[i] = r7_c[i][34] ? -r7_c[i] : r7_c[i];
        end
        n_side2.ob     = r7_ob;
        n_side2.ob.bad = r7_ob.bad || (r7_c[2] == '0);
        n_side2.negx   = r7_c[0][34] ^ r7_c[2][34];
        n_side2.negy   = r7_c[1][34] ^ r7_c[2][34];
        n_side2.ovfx   = ({7'd0, s_cmag[0][33:0]} >= {s_cmag[2][33:0], 7'd0});
        n_side2.ovfy   = ({7'd0, s_cmag[1][33:0]} >= {s_cmag[2][33:0], 7'd0});

        s_xm = r_d2[DIV_LAT-1].ovfx ? 31'h7FFFFFFF : s_qx;
        s_ym = r_d2[DIV_LAT-1].ovfy ? 31'h7FFFFFFF : s_qy;
        n_l9.ox  = r_d2[DIV_LAT-1].ob.ox;
        n_l9.oy  = r_d2[DIV_LAT-1].ob.oy;
        n_l9.bad = r_d2[DIV_LAT-1].ob.bad;
        n_l9.sat = r_d2[DIV_LAT-1].ovfx || r_d2[DIV_LAT-1].ovfy;
        n_l9.xp  = r_d2[DIV_LAT-1].negx ? -$signed({1'b0, s_xm}) : $signed({1'b0, s_xm});
        n_l9.yp  = r_d2[DIV_LAT-1].negy ? -$signed({1'b0, s_ym}) : $signed({1'b0, s_ym});

        s_xsq = r9_l.xp * r9_l.xp;
        s_ysq = r9_l.yp * r9_l.yp;

        s_sq      = {1'b0, r10_xx} + {1'b0, r10_yy};
        s_r2_over = |s_sq[62:55];

        s_df = $signed(r12_kr[63:24]) + 42'sd16777216;
        s_fd = $signed(r14_fdp[63:24]);
        s_ux = $signed(r16_ux[63:24]) + r_px - r16_l.ox;
        s_uy = $signed(r16_uy[63:24]) + r_py - r16_l.oy;

        n_l11     = r10_l;
        n_l11.sat = r10_l.sat || s_r2_over;
        n_l13     = r12_l;
        n_l13.sat = r12_l.sat || f_over(s_df);
        n_l15     = r14_l;
        n_l15.sat = r14_l.sat || f_over(s_fd);
    end

    // Dividers
    for (genvar j = 0; j < 9; j++) begin : g_rot_div
        rr_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_dvd ({r4_abs[j], 30'd0}),
            .i_dsr ({1'b0, r4_n}),
            .o_quo (s_q1[j])
        );
    end

    rr_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_dvd ({5'd0, r8_absx, 24'd0}),
        .i_dsr (r8_absz),
        .o_quo (s_qx)
    );

    rr_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_dvd ({5'd0, r8_absy, 24'd0}),
        .i_dsr (r8_absz),
        .o_quo (s_qy)
    );

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_qw <= i_quat_w;  r1_qx <= i_quat_x;
            r1_qy <= i_quat_y;  r1_qz <= i_quat_z;
            r1_e.tx   <= i_trans_x;  r1_e.ty   <= i_trans_y;  r1_e.tz   <= i_trans_z;
            r1_e.pt_x <= i_point_x;  r1_e.pt_y <= i_point_y;  r1_e.pt_z <= i_point_z;
            r1_e.ox   <= i_obs_x;    r1_e.oy   <= i_obs_y;

            r2_ww <= s_ww[63:32];  r2_xx <= s_xx[63:32];
            r2_yy <= s_yy[63:32];  r2_zz <= s_zz[63:32];
            r2_xy <= s_xy[63:32];  r2_xz <= s_xz[63:32];
            r2_yz <= s_yz[63:32];  r2_wx <= s_wx[63:32];
            r2_wy <= s_wy[63:32];  r2_wz <= s_wz[63:32];
            r2_e  <= r1_e;

            r3_n <= s_n[32:0];
            for (int j = 0; j < 9; j++) begin
                r3_a[j] <= s_a[j];
            end
            r3_e <= r2_e;

            for (int j = 0; j < 9; j++) begin
                r4_abs[j] <= s_mag[j][32:0];
            end
            r4_n    <= r3_n;
            r4_side <= n_side1;

            r_d1[0] <= r4_side;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_d1[k] <= r_d1[k-1];
            end

            for (int j = 0; j < 9; j++) begin
                r5_r[j] <= r_d1[DIV_LAT-1].neg[j] ? -$signed({1'b0, s_rmag[j]})
                                                  : $signed({1'b0, s_rmag[j]});
            end
            r5_e   <= r_d1[DIV_LAT-1].e;
            r5_bad <= r_d1[DIV_LAT-1].bad;

            for (int j = 0; j < 9; j++) begin
                r6_m[j] <= r5_r[j] * s_pt[j % 3];
            end
            r6_e   <= r5_e;
            r6_bad <= r5_bad;

            for (int i = 0; i < 3; i++) begin
                r7_c[i] <= $signed(s_sum[i][63:30]) + s_tr[i];
            end
            r7_ob.ox  <= r6_e.ox;
            r7_ob.oy  <= r6_e.oy;
            r7_ob.bad <= r6_bad;

            r8_absx <= s_cmag[0][33:0];
            r8_absy <= s_cmag[1][33:0];
            r8_absz <= s_cmag[2][33:0];
            r8_side <= n_side2;

            r_d2[0] <= r8_side;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_d2[k] <= r_d2[k-1];
            end

            r9_l <= n_l9;

            r10_xx <= s_xsq[61:0];
            r10_yy <= s_ysq[61:0];
            r10_l  <= r9_l;

            r11_r2 <= s_r2_over ? 31'h7FFFFFFF : s_sq[54:24];
            r11_l  <= n_l11;

            r12_kr <= r_k * $signed({1'b0, r11_r2});
            r12_l  <= r11_l;

            r13_dist <= f_clamp(s_df);
            r13_l    <= n_l13;

            r14_fdp <= $signed({1'b0, r_focal}) * r13_dist;
            r14_l   <= r13_l;

            r15_fd <= f_clamp(s_fd);
            r15_l  <= n_l15;

            r16_ux <= r15_fd * r15_l.xp;
            r16_uy <= r15_fd * r15_l.yp;
            r16_l  <= r15_l;

            // A zero norm or zero depth forces a clean zero result.
            r_res_x <= r16_l.bad ? 32'sd0 : f_clamp(s_ux);
            r_res_y <= r16_l.bad ? 32'sd0 : f_clamp(s_uy);
            r_bad   <= r16_l.bad;
            r_sat   <= !r16_l.bad && (r16_l.sat || f_over(s_ux) || f_over(s_uy));
        end
    end

    assign o_residual_x = r_res_x;
    assign o_residual_y = r_res_y;
    assign o_bad_divide = r_bad;
    assign o_saturated  = r_sat;

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_divide |-> (o_residual_x == 0) && (o_residual_y == 0)
                                    && !o_saturated)
        else $error("bad divide result is not cleared");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while output register is empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
`endif

endmodule

// ===== tb/sv/rr_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rr_checker
// Watches the observation and residual channels and the register writes of
// the reprojection residual block. Each accepted observation is projected
// here and the predicted residual is queued. Each accepted result is then
// compared field by field with the oldest queued prediction.
// ============================================================================
module rr_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [11:0][31:0]  i_obs_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_residual_x,
    input  logic signed [31:0] i_residual_y,
    input  logic               i_bad_divide,
    input  logic               i_saturated,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import rr_pkg::*;

    localparam longint ONE_Q24 = 64'sd16777216;
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic               bad;
        logic               sat;
    } t_residual;

    t_residual expected_residuals[$];

    longint focal;
    longint prin_x;
    longint prin_y;
    longint kcoef;
    int     fails = 0;

    function automatic longint clip(input longint v, input longint lo, input longint hi,
                                    inout bit flag);
        if (v < lo) begin
            flag = 1'b1;
            return lo;
        end
        if (v > hi) begin
            flag = 1'b1;
            return hi;
        end
        return v;
    endfunction

    function automatic t_residual project_observation(input logic [11:0][31:0] f);
        longint w, x, y, z, n;
        longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint rot[9];
        longint tv[3], pv[3], cam[3];
        longint xp, yp, r2, dscale, fd;
        bit sat;
        t_residual res;
        w = $signed(f[0]);
        x = $signed(f[1]);
        y = $signed(f[2]);
        z = $signed(f[3]);
        for (int i = 0; i < 3; i++) begin
            tv[i] = $signed(f[4 + i]);
            pv[i] = $signed(f[7 + i]);
        end
        ww = (w * w) >>> 32; xx = (x * x) >>> 32;
        yy = (y * y) >>> 32; zz = (z * z) >>> 32;
        xy = (x * y) >>> 32; xz = (x * z) >>> 32;
        yz = (y * z) >>> 32; wx = (w * x) >>> 32;
        wy = (w * y) >>> 32; wz = (w * z) >>> 32;
        n = ww + xx + yy + zz;
        res = '{32'sd0, 32'sd0, 1'b1, 1'b0};
        if (n == 0)
            return res;
        rot[0] = ww + xx - yy - zz; rot[1] = 2 * (xy - wz); rot[2] = 2 * (xz + wy);
        rot[3] = 2 * (xy + wz); rot[4] = ww - xx + yy - zz; rot[5] = 2 * (yz - wx);
        rot[6] = 2 * (xz - wy); rot[7] = 2 * (yz + wx); rot[8] = ww - xx - yy + zz;
        // The division rounds toward zero; rounding can push an entry a hair
        // past one, which is clipped quietly.
        for (int i = 0; i < 9; i++) begin
            rot[i] = (rot[i] * ONE_Q30) / n;
            if (rot[i] > ONE_Q30)
                rot[i] = ONE_Q30;
            if (rot[i] < -ONE_Q30)
                rot[i] = -ONE_Q30;
        end
        for (int i = 0; i < 3; i++)
            cam[i] = ((rot[3*i] * pv[0] + rot[3*i+1] * pv[1] + rot[3*i+2] * pv[2]) >>> 30)
                     + tv[i];
        if (cam[2] == 0)
            return res;
        sat = 1'b0;
        xp = clip((cam[0] * ONE_Q24) / cam[2], -I32_MAX, I32_MAX, sat);
        yp = clip((cam[1] * ONE_Q24) / cam[2], -I32_MAX, I32_MAX, sat);
        r2 = clip((xp * xp + yp * yp) >>> 24, 0, I32_MAX, sat);
        dscale = clip(ONE_Q24 + ((kcoef * r2) >>> 24), I32_MIN, I32_MAX, sat);
        fd = clip((focal * dscale) >>> 24, I32_MIN, I32_MAX, sat);
        res.res_x = 32'(clip(((fd * xp) >>> 24) + prin_x - longint'($signed(f[10])),
                             I32_MIN, I32_MAX, sat));
        res.res_y = 32'(clip(((fd * yp) >>> 24) + prin_y - longint'($signed(f[11])),
                             I32_MIN, I32_MAX, sat));
        res.bad = 1'b0;
        res.sat = sat;
        return res;
    endfunction

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fails++;
    endtask

    assign o_fail_count = fails;

    always @(posedge i_clk) begin
        t_residual want;
        if (!i_rst_n) begin
            focal  <= 65536;
            prin_x <= 0;
            prin_y <= 0;
            kcoef  <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FOCAL: focal  <= longint'({1'b0, i_cfg_data[30:0]});
                    CFG_PX:    prin_x <= longint'($signed(i_cfg_data));
                    CFG_PY:    prin_y <= longint'($signed(i_cfg_data));
                    CFG_K:     kcoef  <= longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_residuals.push_back(project_observation(i_obs_item));
            if (i_out_valid && !i_out_stall) begin
                if (expected_residuals.size() == 0) begin
                    report("result transfer with no observation outstanding");
                end else begin
                    want = expected_residuals.pop_front();
                    if (i_residual_x !== want.res_x)
                        report($sformatf("residual_x %0d, expected %0d",
                                         i_residual_x, want.res_x));
                    if (i_residual_y !== want.res_y)
                        report($sformatf("residual_y %0d, expected %0d",
                                         i_residual_y, want.res_y));
                    if (i_bad_divide !== want.bad)
                        report($sformatf("bad_divide %b, expected %b",
                                         i_bad_divide, want.bad));
                    if (i_saturated !== want.sat)
                        report($sformatf("saturated %b, expected %b",
                                         i_saturated, want.sat));
                end
            end
        end
        o_pending = expected_residuals.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Stimulus for the reprojection residual block: directed observations with
// the degenerate and extreme cases, then random observations over several
// intrinsic settings and handshake pressure phases. Checking is done by
// rr_checker.
// ============================================================================
module testbench;
    import rr_pkg::*;

    localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
    localparam logic [31:0] POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX  = 32'h8000_0000;
    localparam int          DRAIN    = 90;
    localparam int          WATCHDOG = 20000;
    localparam int          PHASES   = 8;
    localparam int          PER_PHASE = 116;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [11:0][31:0] obs_item;
    logic              o_valid;
    logic              i_stall;
    logic signed [31:0] o_residual_x;
    logic signed [31:0] o_residual_y;
    logic              o_bad_divide;
    logic              o_saturated;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [31:0]       i_cfg_data;

    int fail_count;
    int pending;
    int send_idle_pct;
    int stall_pct;
    bit hold_go;
    bit hold_taken;
    int hold_left;
    int quiet_cycles;

    reprojection_residual_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_quat_w     (obs_item[0]),
        .i_quat_x     (obs_item[1]),
        .i_quat_y     (obs_item[2]),
        .i_quat_z     (obs_item[3]),
        .i_trans_x    (obs_item[4]),
        .i_trans_y    (obs_item[5]),
        .i_trans_z    (obs_item[6]),
        .i_point_x    (obs_item[7]),
        .i_point_y    (obs_item[8]),
        .i_point_z    (obs_item[9]),
        .i_obs_x      (obs_item[10]),
        .i_obs_y      (obs_item[11]),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_residual_x (o_residual_x),
        .o_residual_y (o_residual_y),
        .o_bad_divide (o_bad_divide),
        .o_saturated  (o_saturated),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    rr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_obs_item   (obs_item),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_residual_x (o_residual_x),
        .i_residual_y (o_residual_y),
        .i_bad_divide (o_bad_divide),
        .i_saturated  (o_saturated),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Receiver side. A single long hold-off lets the pipeline fill and push
    // back on the sender.
    initial begin
        i_stall    = 1'b0;
        hold_taken = 1'b0;
        hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    task automatic send_observation(input logic [11:0][31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        obs_item <= v;
        i_valid  <= 1'b1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_intrinsic(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [11:0][31:0] directed_observation(input int k);
        logic [11:0][31:0] v;
        v = '0;
        v[0] = ONE_Q30;
        case (k)
            0: begin
                v[7] = 32'h0001_0000; v[8] = 32'h0002_0000; v[9] = 32'h000A_0000;
            end
            1: v = '0;
            2: begin
                v[0] = 32'd1; v[1] = 32'd1; v[9] = 32'h0001_0000;
            end
            3: v[7] = 32'h0003_0000;
            4: begin
                v[9] = 32'hFFFB_0000; v[6] = 32'h0005_0000; v[7] = 32'h0001_0000;
            end
            5: for (int i = 0; i < 12; i++) v[i] = POS_MAX;
            6: for (int i = 0; i < 12; i++) v[i] = NEG_MAX;
            7: begin
                v[7] = POS_MAX; v[9] = 32'd1;
            end
            8: begin
                v[7] = 32'h0003_0000; v[8] = 32'h0004_0000; v[9] = 32'hFFFE_0000;
            end
            9: begin
                v[0] = 32'h2D41_3CCD; v[3] = 32'h2D41_3CCD;
                v[7] = 32'h0001_0000; v[9] = 32'h0004_0000; v[6] = 32'h0001_0000;
            end
            10: begin
                v[0] = 32'hC000_0000; v[8] = 32'h0002_0000; v[9] = 32'h0003_0000;
            end
            11: begin
                v[9] = 32'h0001_0000; v[10] = POS_MAX; v[11] = NEG_MAX;
            end
            12: begin
                v[0] = POS_MAX; v[1] = POS_MAX; v[8] = 32'h0001_0000;
                v[9] = 32'h0002_0000;
            end
            13: begin
                v[0] = 32'd0; v[1] = ONE_Q30; v[9] = 32'hFFF6_0000;
                v[4] = 32'h0000_8000;
            end
            14: begin
                v[0] = NEG_MAX; v[2] = POS_MAX; v[4] = NEG_MAX; v[5] = POS_MAX;
                v[6] = 32'h0100_0000; v[7] = 32'hFFFF_FFFF; v[10] = 32'd1;
            end
            default: for (int i = 0; i < 12; i++) v[i] = $urandom;
        endcase
        return v;
    endfunction

    // Most observations look like a real scene: any rotation, a point within
    // a few hundred units and a camera in front of it. The rest are raw noise,
    // some with a tiny quaternion, a few built to land exactly on zero depth.
    function automatic logic [11:0][31:0] random_observation();
        logic [11:0][31:0] v;
        int pick;
        pick = $urandom_range(99);
        for (int i = 0; i < 12; i++) v[i] = $urandom;
        if (pick < 75) begin
            for (int i = 4; i < 12; i++)
                v[i] = 32'($signed(v[i]) >>> $urandom_range(14, 6));
            v[6] = 32'($urandom_range(2000, 50)) << 16 | ($urandom & 32'hFFFF);
            v[9] = 32'($signed(v[9]) >>> 4);
        end else if (pick < 82) begin
            v[0] = ONE_Q30; v[1] = '0; v[2] = '0; v[3] = '0;
            v[9] = 32'($signed(v[9]) >>> 2);
            v[6] = -v[9];
        end else if (pick < 86) begin
            for (int i = 0; i < 4; i++)
                v[i] = 32'($signed(v[i]) >>> $urandom_range(31, 16));
        end
        return v;
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        obs_item      = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_FOCAL;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_go       = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < 16; k++)
            send_observation(directed_observation(k));

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_pipeline();
            case (ph)
                0: begin
                    write_intrinsic(CFG_FOCAL, 32'd500 << 16);
                    write_intrinsic(CFG_PX, 32'd320 << 16);
                    write_intrinsic(CFG_PY, 32'd240 << 16);
                    write_intrinsic(CFG_K, 32'($signed($urandom) >>> 8));
                end
                1: begin
                    write_intrinsic(CFG_FOCAL, POS_MAX);
                    write_intrinsic(CFG_PX, POS_MAX);
                    write_intrinsic(CFG_PY, POS_MAX);
                    write_intrinsic(CFG_K, POS_MAX);
                end
                2: begin
                    write_intrinsic(CFG_FOCAL, 32'd0);
                    write_intrinsic(CFG_PX, NEG_MAX);
                    write_intrinsic(CFG_PY, NEG_MAX);
                    write_intrinsic(CFG_K, NEG_MAX);
                end
                3: begin
                    write_intrinsic(CFG_FOCAL, 32'h8001_0000);
                    write_intrinsic(CFG_PX, 32'd0);
                    write_intrinsic(CFG_PY, 32'd0);
                    write_intrinsic(CFG_K, 32'd0);
                end
                default: begin
                    write_intrinsic(CFG_FOCAL, $urandom);
                    write_intrinsic(CFG_PX, $urandom);
                    write_intrinsic(CFG_PY, $urandom);
                    write_intrinsic(CFG_K, 32'($signed($urandom) >>> $urandom_range(12)));
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 9; stall_pct = 9; end
            endcase
            for (int n = 0; n < PER_PHASE; n++) begin
                if (ph == 0 && n == 10)
                    hold_go = 1'b1;
                if (ph == 3 && n == 50)
                    drain_pipeline();
                send_observation(random_observation());
            end
        end

        drain_pipeline();
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
